FILE: design/qdec_pkg.sv
package qdec_pkg;

    localparam int unsigned ENCODERS_DEF = 4;

    localparam int unsigned IDX_W     = 2;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned POS_W     = 32;
    localparam int unsigned DELTA_W   = 6;
    localparam int unsigned WINDOW_W  = 20;
    localparam int unsigned MULT_W    = 5;
    localparam int unsigned SUB_W     = 4;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 40;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FAST_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_MULT   = 2'd1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 20'd5000;
    localparam logic [MULT_W-1:0]   MULT_RESET   = 5'd4;
    localparam logic [MULT_W-1:0]   MULT_MIN     = 5'd1;
    localparam logic [MULT_W-1:0]   MULT_MAX     = 5'd16;

    localparam logic [1:0] AB_RESET = 2'b11;

    // key = {previous AB, current AB}
    localparam logic signed [1:0] TRANS_TABLE [16] = '{
        2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
        -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
    };

    typedef struct packed {
        logic [IDX_W-1:0]  encoder_index;
        logic [1:0]        ab;
        logic [TIME_W-1:0] now_us;
    } item_t;

    typedef struct packed {
        logic signed [POS_W-1:0]   position;
        logic signed [DELTA_W-1:0] step_delta;
        logic                      was_fast;
    } result_t;

    typedef struct packed {
        logic [WINDOW_W-1:0] fast_window_us;
        logic [MULT_W-1:0]   fast_mult_eff;   // already clamped to 1..16
    } cfg_t;

endpackage

FILE: design/quadrature_decoder_accel.sv
// Quadrature decoder with velocity boost, several encoder channels.
//
// Input stream (s_*): one word per pin-change sample: channel index, A and B
// levels and a free-running microsecond timestamp. Output stream (m_*): one
// word per input word, in order: updated position, step applied, fast flag.
// Config channel (cfg_*): index 0 writes the fast window in microseconds,
// index 1 the fast step size from data bits 4:0 (0 taken as 1, above 16 as 16);
// other indexes are ignored. cfg_ready is always high; write only while idle.
//
// An accepted word goes into the input register, its result into the output
// register that drives m_tdata. Throughput: one word per cycle while
// m_tready is high. The per-channel state lives in flops and is read,
// updated and written back combinationally between the two registers, so
// consecutive words to the same channel need no forwarding.
//
// Reset: every channel starts with AB = both high, zero sub-step count,
// position and timestamps; window 5000 us, step size 4.
// Stall: while m_tready is low the output word holds; one more word can sit
// in the input register, after which s_tready drops.
module quadrature_decoder_accel #(
    parameter int unsigned ENCODERS = qdec_pkg::ENCODERS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // [1:0] encoder_index, [2] pin_a_level, [3] pin_b_level, [35:4] now_us
    input  logic [qdec_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,

    // [31:0] position, [37:32] step_delta, [38] was_fast
    output logic [qdec_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qdec_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qdec_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import qdec_pkg::*;

    item_t   item_reg;
    item_t   item_next;
    logic    in_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    out_valid_reg;
    logic    advance;
    logic    update;
    cfg_t    cfg;

    // output slot free or draining this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign update   = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign item_next.encoder_index = s_tdata[1:0];
    assign item_next.ab            = {s_tdata[2], s_tdata[3]};
    assign item_next.now_us        = s_tdata[35:4];

    qdec_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    qdec_core #(
        .ENCODERS (ENCODERS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (update),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_next;
        end
        if (update)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, result_reg.was_fast, result_reg.step_delta,
                       result_reg.position};

`ifndef ASSERT_OFF
    a_fast_has_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[38] |-> m_tdata[37:32] != 6'd0)
        else $error("fast flag without a step");
    a_delta_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[37:32]) >= -6'sd16 &&
                      $signed(m_tdata[37:32]) <= 6'sd16))
        else $error("step outside -16..16");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input blocked with room in the pipe");
    a_feed_out: assert property (@(posedge clk) disable iff (!rst_n)
        update |=> out_valid_reg)
        else $error("processed word lost");
`endif

endmodule

FILE: design/qdec_cfg.sv
module qdec_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [qdec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qdec_pkg::CFG_DATA_W-1:0]  cfg_data,
    output qdec_pkg::cfg_t                   cfg
);
    import qdec_pkg::*;

    logic [WINDOW_W-1:0] window_reg;
    logic [MULT_W-1:0]   mult_reg;
    logic [MULT_W-1:0]   mult_next;
    logic [MULT_W-1:0]   mult_raw;

    assign cfg_ready = 1'b1;

    // clamp once at write time
    always_comb
    begin
        mult_raw = cfg_data[MULT_W-1:0];
        if (mult_raw < MULT_MIN)
        begin
            mult_next = MULT_MIN;
        end
        else if (mult_raw > MULT_MAX)
        begin
            mult_next = MULT_MAX;
        end
        else
        begin
            mult_next = mult_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            mult_reg   <= MULT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FAST_WINDOW: window_reg <= cfg_data[WINDOW_W-1:0];
                REG_FAST_MULT:   mult_reg   <= mult_next;
                default:         ;
            endcase
        end
    end

    assign cfg.fast_window_us = window_reg;
    assign cfg.fast_mult_eff  = mult_reg;

`ifndef ASSERT_OFF
    a_mult_range: assert property (@(posedge clk) disable iff (!rst_n)
        mult_reg >= MULT_MIN && mult_reg <= MULT_MAX)
        else $error("fast multiplier outside 1..16");
    a_mult_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index == REG_FAST_MULT && cfg_data[MULT_W-1:0] == '0
        |=> mult_reg == MULT_MIN)
        else $error("zero multiplier not mapped to one");
    a_window_keep: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_valid |=> $stable(window_reg))
        else $error("window changed without a write");
`endif

endmodule

FILE: design/qdec_core.sv
module qdec_core #(
    parameter int unsigned ENCODERS = qdec_pkg::ENCODERS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              update,
    input  qdec_pkg::item_t   item,
    input  qdec_pkg::cfg_t    cfg,
    output qdec_pkg::result_t result
);
    import qdec_pkg::*;

    localparam int unsigned ADDR_W = (ENCODERS > 1) ? $clog2(ENCODERS) : 1;

    logic [1:0]              prev_ab_reg   [ENCODERS];
    logic signed [SUB_W-1:0] sub_reg       [ENCODERS];
    logic [POS_W-1:0]        pos_reg       [ENCODERS];
    logic [TIME_W-1:0]       up_time_reg   [ENCODERS];
    logic [TIME_W-1:0]       down_time_reg [ENCODERS];

    logic [ADDR_W-1:0]       addr;
    logic                    in_range;
    logic [3:0]              key;
    logic signed [SUB_W-1:0] sub_sum;
    logic signed [SUB_W-1:0] sub_next;
    logic                    go_up;
    logic                    go_down;
    logic [TIME_W-1:0]       last_time;
    logic [TIME_W-1:0]       elapsed;
    logic                    fast;
    logic [MULT_W-1:0]       mag;
    logic [POS_W-1:0]        pos_next;
    logic [DELTA_W-1:0]      delta;
    logic                    write_en;

    always_comb
    begin
        addr     = ADDR_W'(item.encoder_index);
        in_range = 32'(item.encoder_index) < ENCODERS;
        key      = {prev_ab_reg[addr], item.ab};
        sub_sum  = sub_reg[addr] + SUB_W'(TRANS_TABLE[key]);
        go_up    = (sub_sum == 4'sd4);
        go_down  = (sub_sum == -4'sd4);

        last_time = go_up ? up_time_reg[addr] : down_time_reg[addr];
        elapsed   = item.now_us - last_time;   // wraps mod 2^32
        fast      = (go_up || go_down) && (elapsed < TIME_W'(cfg.fast_window_us));
        mag       = fast ? cfg.fast_mult_eff : MULT_MIN;

        if (go_up)
        begin
            pos_next = pos_reg[addr] + POS_W'(mag);
            delta    = DELTA_W'(mag);
        end
        else if (go_down)
        begin
            pos_next = pos_reg[addr] - POS_W'(mag);
            delta    = -DELTA_W'(mag);
        end
        else
        begin
            pos_next = pos_reg[addr];
            delta    = '0;
        end

        sub_next = (go_up || go_down) ? '0 : sub_sum;
        write_en = update && in_range;

        if (in_range)
        begin
            result.position   = pos_next;
            result.step_delta = delta;
            result.was_fast   = fast;
        end
        else
        begin
            result = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENCODERS; i++)
            begin
                prev_ab_reg[i]   <= AB_RESET;
                sub_reg[i]       <= '0;
                pos_reg[i]       <= '0;
                up_time_reg[i]   <= '0;
                down_time_reg[i] <= '0;
            end
        end
        else if (write_en)
        begin
            prev_ab_reg[addr] <= item.ab;
            sub_reg[addr]     <= sub_next;
            pos_reg[addr]     <= pos_next;
            if (go_up)
            begin
                up_time_reg[addr] <= item.now_us;
            end
            if (go_down)
            begin
                down_time_reg[addr] <= item.now_us;
            end
        end
    end

`ifndef ASSERT_OFF
    a_sub_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        write_en |-> (sub_next >= -4'sd3 && sub_next <= 4'sd3))
        else $error("sub-step count left -3..3");
    a_pos_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        write_en |=> pos_reg[$past(addr)] == $past(pos_next))
        else $error("position not written back");
    a_out_of_range_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !in_range |-> result == '0)
        else $error("out-of-range channel gave a result");
`endif

endmodule

FILE: dv/qdec_checker.sv
module qdec_checker
    import qdec_pkg::*;
#(
    parameter int unsigned ENCODERS = ENCODERS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic [IN_DATA_W-1:0]   s_tdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,

    input  logic [OUT_DATA_W-1:0]  m_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,

    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    output int unsigned            mismatches,
    output int unsigned            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // predicted per-channel state and register copies
    logic [1:0]          last_ab    [ENCODERS];
    int                  sub_count  [ENCODERS];
    logic [POS_W-1:0]    pos        [ENCODERS];
    logic [TIME_W-1:0]   up_stamp   [ENCODERS];
    logic [TIME_W-1:0]   down_stamp [ENCODERS];
    logic [WINDOW_W-1:0] window;
    logic [MULT_W-1:0]   mult_raw;

    result_t     expected_motion [$];
    int unsigned error_count = 0;
    int unsigned pending_count = 0;

    assign mismatches  = error_count;
    assign outstanding = pending_count;

    // quarter step for key = {previous AB, current AB}
    function automatic int quarter_step(logic [3:0] key);
        case (key)
            4'd2, 4'd4, 4'd11, 4'd13: return 1;
            4'd1, 4'd7, 4'd8, 4'd14:  return -1;
            default:                  return 0;
        endcase
    endfunction

    function automatic result_t advance_encoder(logic [IDX_W-1:0] enc, logic [1:0] ab,
                                                logic [TIME_W-1:0] now);
        result_t            r;
        int                 sub;
        int                 step;
        logic [TIME_W-1:0]  since;
        logic [MULT_W-1:0]  boost;
        logic               up;
        r = '0;
        if (enc >= ENCODERS)
            return r;
        sub = sub_count[enc] + quarter_step({last_ab[enc], ab});
        last_ab[enc] = ab;
        if (sub > 3 || sub < -3)
        begin
            up    = (sub > 3);
            since = now - (up ? up_stamp[enc] : down_stamp[enc]);
            boost = (mult_raw < MULT_MIN) ? MULT_MIN :
                    (mult_raw > MULT_MAX) ? MULT_MAX : mult_raw;
            step  = 1;
            if (since < TIME_W'(window))
            begin
                step       = int'(boost);
                r.was_fast = 1'b1;
            end
            if (up)
                up_stamp[enc] = now;
            else
            begin
                down_stamp[enc] = now;
                step = -step;
            end
            pos[enc]     = pos[enc] + POS_W'(step);
            r.step_delta = DELTA_W'(step);
            sub          = 0;
        end
        sub_count[enc] = sub;
        r.position     = pos[enc];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENCODERS; i++)
            begin
                last_ab[i]    = AB_RESET;
                sub_count[i]  = 0;
                pos[i]        = '0;
                up_stamp[i]   = '0;
                down_stamp[i] = '0;
            end
            window   = WINDOW_RESET;
            mult_raw = MULT_RESET;
            expected_motion.delete();
            pending_count = 0;
        end
        else
        begin
            // results first: an output word is never the one accepted this edge
            if (m_tvalid && m_tready)
            begin
                got.position   = m_tdata[31:0];
                got.step_delta = m_tdata[37:32];
                got.was_fast   = m_tdata[38];
                if (expected_motion.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected word, got pos %0d delta %0d fast %0b",
                             $time, got.position, got.step_delta, got.was_fast);
                end
                else
                begin
                    want = expected_motion.pop_front();
                    pending_count--;
                    if (got !== want)
                    begin
                        error_count++;
                        $display({"%0t: expected pos %0d delta %0d fast %0b, ",
                                  "got pos %0d delta %0d fast %0b"},
                                 $time, want.position, want.step_delta, want.was_fast,
                                 got.position, got.step_delta, got.was_fast);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FAST_WINDOW: window   = cfg_data;
                    REG_FAST_MULT:   mult_raw = cfg_data[MULT_W-1:0];
                    default:         ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                // s_tdata: [1:0] index, [2] A, [3] B, [35:4] timestamp
                expected_motion.push_back(advance_encoder(s_tdata[1:0],
                                                          {s_tdata[2], s_tdata[3]},
                                                          s_tdata[35:4]));
                pending_count++;
            end
        end
    end

endmodule

FILE: dv/quadrature_decoder_accel_tb.sv
module quadrature_decoder_accel_tb;
    import qdec_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // random part: items per register setting, six settings in all
    localparam int PHASE_ITEMS = 130;
    // receiver hold-off, long enough to back the block up into s_tready
    localparam int HOLD_CYCLES = 60;
    // indexes with no register behind them; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int unsigned mismatches;
    int unsigned outstanding;

    // calm: neither side idles; hold_req: receiver goes quiet for a while
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    // stimulus-side view: last AB driven per channel and the running timestamp
    logic [1:0]        ab_state [ENCODERS_DEF];
    logic [TIME_W-1:0] stamp;

    quadrature_decoder_accel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    qdec_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Next AB on a legal quadrature edge: up runs 11-01-00-10, down the reverse.
    function automatic logic [1:0] gray_next(logic [1:0] ab, bit up);
        case (ab)
            2'b11:   return up ? 2'b01 : 2'b10;
            2'b01:   return up ? 2'b00 : 2'b11;
            2'b00:   return up ? 2'b10 : 2'b01;
            default: return up ? 2'b11 : 2'b00;
        endcase
    endfunction

    // Mostly short hops so all edges of a step can land in the fast window, some
    // zero gaps (for a window of 1), some long gaps, and a few jumps anywhere
    // in the 32-bit range so wraparound and every timestamp bit are covered.
    function automatic logic [TIME_W-1:0] advance_clock();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            ;
        else if (r < 60)
            stamp = stamp + $urandom_range(400);
        else if (r < 85)
            stamp = stamp + $urandom_range(30000);
        else if (r < 95)
            stamp = stamp + $urandom_range(2000000);
        else
            stamp = $urandom();
        return stamp;
    endfunction

    // One pin-change word. Gaps go in front of the word, so they fall between
    // any two words including back-to-back edges on one channel.
    task automatic send_sample(input logic [1:0] enc, input logic [1:0] ab,
                               input logic [TIME_W-1:0] now);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        // {pad, timestamp, B, A, index}
        s_tdata  <= {4'b0, now, ab[0], ab[1], enc};
        s_tvalid <= 1'b1;
        ab_state[enc] = ab;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Register writes only happen with the block drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait until every accepted word has come back.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Random traffic: three quarters are legal edge runs on one channel (with
    // the odd reversal) so the sub-step count actually reaches a step; the
    // rest is random AB: repeats, single edges or illegal double transitions.
    task automatic churn_encoders(input int quota);
        int         sent;
        int         len;
        bit         up;
        logic [1:0] enc;
        sent = 0;
        while (sent < quota)
        begin
            enc = 2'($urandom_range(3));
            if ($urandom_range(99) < 75)
            begin
                up  = 1'($urandom_range(1));
                len = $urandom_range(1, 12);
                repeat (len)
                begin
                    if ($urandom_range(9) == 0)
                        up = !up;
                    send_sample(enc, gray_next(ab_state[enc], up), advance_clock());
                    sent++;
                end
            end
            else
            begin
                send_sample(enc, 2'($urandom_range(3)), advance_clock());
                sent++;
            end
        end
    endtask

    // Result side: random stalls, none while calm, and one long hold-off on
    // request, counted here so the sender keeps pushing meanwhile.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 26);
        end
    end

    initial
    begin
        for (int i = 0; i < ENCODERS_DEF; i++)
            ab_state[i] = AB_RESET;
        stamp = '0;
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset settings (window 5000, step 4).
        // ch0: full up cycle shortly after time 0 -> fast step (stamp starts at 0)
        send_sample(2'd0, 2'b01, 32'd100);
        send_sample(2'd0, 2'b00, 32'd200);
        send_sample(2'd0, 2'b10, 32'd300);
        send_sample(2'd0, 2'b11, 32'd400);
        // ch0: another up cycle far later -> slow single step
        send_sample(2'd0, 2'b01, 32'd100000);
        send_sample(2'd0, 2'b00, 32'd100010);
        send_sample(2'd0, 2'b10, 32'd100020);
        send_sample(2'd0, 2'b11, 32'd100030);
        // ch1: down cycle near the top of time -> slow, position goes negative
        send_sample(2'd1, 2'b10, 32'hFFFF_FFF0);
        send_sample(2'd1, 2'b00, 32'hFFFF_FFF1);
        send_sample(2'd1, 2'b01, 32'hFFFF_FFF2);
        send_sample(2'd1, 2'b11, 32'hFFFF_FFF3);
        // ch1: down again across the time wrap -> fast by modular difference
        send_sample(2'd1, 2'b10, 32'h0000_0004);
        send_sample(2'd1, 2'b00, 32'h0000_0008);
        send_sample(2'd1, 2'b01, 32'h0000_000C);
        send_sample(2'd1, 2'b11, 32'h0000_0010);
        // ch2: illegal jump, repeat, illegal jump back -> no motion
        send_sample(2'd2, 2'b00, 32'h0000_0000);
        send_sample(2'd2, 2'b00, 32'hFFFF_FFFF);
        send_sample(2'd2, 2'b11, 32'h8000_0000);
        // ch3: edges up short of a step, then edges back; sub-count falls back without a step
        send_sample(2'd3, 2'b01, 32'hFFFF_FFFF);
        send_sample(2'd3, 2'b00, 32'h0000_0000);
        send_sample(2'd3, 2'b10, 32'h5555_5555);
        send_sample(2'd3, 2'b00, 32'hAAAA_AAAA);
        send_sample(2'd3, 2'b01, 32'h7FFF_FFFF);
        stamp = 32'h0001_0000;
        churn_encoders(PHASE_ITEMS);
        drain();

        // wide window, biggest step; receiver holds off at the start
        write_reg(REG_FAST_WINDOW, 20'd1000000);
        write_reg(REG_FAST_MULT, 20'd16);
        hold_req = 1'b1;
        churn_encoders(PHASE_ITEMS);
        drain();

        // window 0: nothing is ever fast; step 0 behaves as 1; no idling at all
        write_reg(REG_FAST_WINDOW, 20'd0);
        write_reg(REG_FAST_MULT, 20'd0);
        calm = 1'b1;
        churn_encoders(PHASE_ITEMS);
        drain();
        calm = 1'b0;

        // window all ones (the widest the field holds), step 31 clamps to 16;
        // writes to unused indexes must change nothing
        write_reg(REG_FAST_WINDOW, 20'hFFFFF);
        write_reg(REG_FAST_MULT, 20'd31);
        write_reg(REG_SPARE_A, 20'h00001);
        write_reg(REG_SPARE_B, 20'hFFFFF);
        churn_encoders(PHASE_ITEMS);
        drain();

        // window 1: fast only on equal timestamps; fast step of size 1
        write_reg(REG_FAST_WINDOW, 20'd1);
        write_reg(REG_FAST_MULT, 20'd1);
        churn_encoders(PHASE_ITEMS);
        drain();

        // random setting; step data carries junk above its 5 bits
        write_reg(REG_FAST_WINDOW, 20'($urandom_range(20'hFFFFF)));
        write_reg(REG_FAST_MULT, 20'($urandom_range(20'hFFFFF)));
        churn_encoders(PHASE_ITEMS);
        drain();

        // give stray words a chance to show up
        repeat (8)
            @(negedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
